// ===== hw/rtl/tlctl_pkg.sv =====
// Shared constants, types and helper functions for the two-level tag lookup.
`default_nettype none

package tlctl_pkg;

	localparam int BLOCK_BYTES  = 8;
	localparam int L1_SETS      = 4;
	localparam int L2_SETS      = 8;
	localparam int ADDR_BITS    = 32;
	localparam int L1_WAYS_DEF  = 2;
	localparam int L2_WAYS_DEF  = 4;

	localparam int IN_ADDR_BITS = 32;
	localparam int CNT_BITS     = 32;

	localparam int EFF_ADDR_BITS = (ADDR_BITS < IN_ADDR_BITS) ? ADDR_BITS : IN_ADDR_BITS;
	localparam int OFS_BITS      = $clog2(BLOCK_BYTES);
	localparam int BLK_BITS      = EFF_ADDR_BITS - OFS_BITS;
	localparam int L1_SET_BITS   = $clog2(L1_SETS);
	localparam int L2_SET_BITS   = $clog2(L2_SETS);
	localparam int L1_IDX_W      = (L1_SET_BITS > 0) ? L1_SET_BITS : 1;
	localparam int L2_IDX_W      = (L2_SET_BITS > 0) ? L2_SET_BITS : 1;
	localparam int L1_TAG_BITS   = BLK_BITS - L1_SET_BITS;
	localparam int L2_TAG_BITS   = BLK_BITS - L2_SET_BITS;
	localparam int MAX_SETS      = (L1_SETS > L2_SETS) ? L1_SETS : L2_SETS;
	localparam int CLR_W         = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;

	localparam logic [1:0] HIT_L1  = 2'd0;
	localparam logic [1:0] HIT_L2  = 2'd1;
	localparam logic [1:0] HIT_MEM = 2'd2;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK
	} state_t;

	// Per-set fill count: 0 .. ways
	function automatic int cnt_bits(input int ways);
		return $clog2(ways + 1);
	endfunction

	// Per-set round-robin pointer: 0 .. ways-1
	function automatic int ptr_bits(input int ways);
		return (ways > 1) ? $clog2(ways) : 1;
	endfunction

	// Set row: {ptr, cnt, tag[ways-1] .. tag[0]}
	function automatic int row_bits(input int ways, input int tag_bits);
		return ways * tag_bits + cnt_bits(ways) + ptr_bits(ways);
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tlctl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tlctl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== hw/rtl/tlctl_set_update.sv =====
// Per-set tag compare and FIFO fill of one cache level row.
`default_nettype none

module tlctl_set_update
	import tlctl_pkg::*;
#(
	parameter int WAYS     = 2,
	parameter int TAG_BITS = 27,
	parameter int ROW_W    = row_bits(WAYS, TAG_BITS)
) (
	input  wire logic [ROW_W-1:0]    row,
	input  wire logic [TAG_BITS-1:0] tag,
	output logic                     hit,
	output logic      [ROW_W-1:0]    row_next
);

	localparam int CNT_W  = cnt_bits(WAYS);
	localparam int PTR_W  = ptr_bits(WAYS);
	localparam int TAGS_W = WAYS * TAG_BITS;

	logic [PTR_W-1:0]  ptr, ptr_next, victim;
	logic [CNT_W-1:0]  cnt, cnt_next;
	logic [TAGS_W-1:0] tags, tags_next;
	logic              full;

	assign {ptr, cnt, tags} = row;

	// ways below the fill count are the valid ones
	always_comb begin
		hit = 1'b0;
		for (int w = 0; w < WAYS; w++) begin
			if ((CNT_W'(w) < cnt) && (tags[w*TAG_BITS +: TAG_BITS] == tag)) begin
				hit = 1'b1;
			end
		end
	end

	assign full   = (cnt == CNT_W'(WAYS));
	assign victim = full ? ptr : PTR_W'(cnt);

	always_comb begin
		tags_next = tags;
		for (int w = 0; w < WAYS; w++) begin
			if (PTR_W'(w) == victim) begin
				tags_next[w*TAG_BITS +: TAG_BITS] = tag;
			end
		end
	end

	assign cnt_next = full ? cnt : cnt + CNT_W'(1);
	assign ptr_next = !full ? ptr :
		((ptr == PTR_W'(WAYS - 1)) ? '0 : ptr + PTR_W'(1));

	assign row_next = {ptr_next, cnt_next, tags_next};

endmodule

`default_nettype wire

// ===== hw/rtl/two_level_cache_tag_lookup_core.sv =====
// Top level of the two-level set-associative tag lookup with FIFO replacement.
//
//  channel | signals                              | direction | accepted when
//  --------+--------------------------------------+-----------+--------------------------
//  in      | in_valid, in_stall, address          | to core   | in_valid & !in_stall
//  out     | out_valid, out_stall, hit_level,     | from core | out_valid & !out_stall
//          | l1/l2 hit/miss counts, memory misses |           |
//
// Each transaction runs as follows: the accept edge reads both set rows from
// the tag RAMs, the next edge compares, writes the filled rows back and loads
// the result. No new transaction is taken in ST_LOOK, while the rows are
// written back. After reset a clearing pass zeroes every set row; in_stall
// stays high meanwhile. A held result only blocks new transactions while
// out_stall keeps it in the output register.
`default_nettype none

module two_level_cache_tag_lookup_core
	import tlctl_pkg::*;
#(
	parameter int L1_WAYS = L1_WAYS_DEF,
	parameter int L2_WAYS = L2_WAYS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic [IN_ADDR_BITS-1:0] address,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic      [1:0]              hit_level,
	output logic      [CNT_BITS-1:0]     l1_hit_count,
	output logic      [CNT_BITS-1:0]     l1_miss_count,
	output logic      [CNT_BITS-1:0]     l2_hit_count,
	output logic      [CNT_BITS-1:0]     l2_miss_count,
	output logic      [CNT_BITS-1:0]     memory_miss_count
);

	localparam int L1_ROW_W = row_bits(L1_WAYS, L1_TAG_BITS);
	localparam int L2_ROW_W = row_bits(L2_WAYS, L2_TAG_BITS);

	state_t state_q, state_d;

	logic [CLR_W-1:0]       clr_idx_q;
	logic [EFF_ADDR_BITS-1:0] addr_eff;
	logic [BLK_BITS-1:0]    blk;
	logic [L1_IDX_W-1:0]    l1_set, l1_set_q, l1_raddr, l1_waddr;
	logic [L2_IDX_W-1:0]    l2_set, l2_set_q, l2_raddr, l2_waddr;
	logic [L1_TAG_BITS-1:0] l1_tag, l1_tag_q;
	logic [L2_TAG_BITS-1:0] l2_tag, l2_tag_q;
	logic [L1_ROW_W-1:0]    l1_rdata, l1_row_next, l1_wdata;
	logic [L2_ROW_W-1:0]    l2_rdata, l2_row_next, l2_wdata;
	logic                   l1_we, l2_we, l1_hit, l2_hit;
	logic                   accept, look, clr_last;
	logic                   out_valid_q;
	logic [1:0]             hit_level_q;
	logic [CNT_BITS-1:0]    l1_hit_q, l1_miss_q, l2_hit_q, l2_miss_q, mem_miss_q;

	// set and tag split of the block address
	assign addr_eff = address[EFF_ADDR_BITS-1:0];
	assign blk      = addr_eff[EFF_ADDR_BITS-1:OFS_BITS];
	assign l1_set   = L1_IDX_W'(blk % L1_SETS);
	assign l2_set   = L2_IDX_W'(blk % L2_SETS);
	assign l1_tag   = L1_TAG_BITS'(blk >> L1_SET_BITS);
	assign l2_tag   = L2_TAG_BITS'(blk >> L2_SET_BITS);

	assign clr_last = (clr_idx_q == CLR_W'(MAX_SETS - 1));
	assign in_stall = (state_q != ST_IDLE) || (out_valid_q && out_stall);
	assign accept   = in_valid && !in_stall;
	assign look     = (state_q == ST_LOOK);

	tlctl_set_update #(
		.WAYS     (L1_WAYS),
		.TAG_BITS (L1_TAG_BITS)
	) u_l1_upd (
		.row      (l1_rdata),
		.tag      (l1_tag_q),
		.hit      (l1_hit),
		.row_next (l1_row_next)
	);

	tlctl_set_update #(
		.WAYS     (L2_WAYS),
		.TAG_BITS (L2_TAG_BITS)
	) u_l2_upd (
		.row      (l2_rdata),
		.tag      (l2_tag_q),
		.hit      (l2_hit),
		.row_next (l2_row_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		l1_we    = 1'b0;
		l2_we    = 1'b0;
		l1_waddr = l1_set_q;
		l2_waddr = l2_set_q;
		l1_wdata = l1_row_next;
		l2_wdata = l2_row_next;
		l1_raddr = l1_set;
		l2_raddr = l2_set;
		case (state_q)
			ST_CLEAR: begin
				l1_we    = ({1'b0, clr_idx_q} < (CLR_W + 1)'(L1_SETS));
				l2_we    = ({1'b0, clr_idx_q} < (CLR_W + 1)'(L2_SETS));
				l1_waddr = L1_IDX_W'(clr_idx_q);
				l2_waddr = L2_IDX_W'(clr_idx_q);
				l1_wdata = '0;
				l2_wdata = '0;
				if (clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				l1_we   = !l1_hit;
				l2_we   = !l1_hit && !l2_hit;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	tlctl_ram #(
		.WIDTH (L1_ROW_W),
		.DEPTH (L1_SETS),
		.AW    (L1_IDX_W)
	) u_l1_ram (
		.clk   (clk),
		.we    (l1_we),
		.waddr (l1_waddr),
		.wdata (l1_wdata),
		.raddr (l1_raddr),
		.rdata (l1_rdata)
	);

	tlctl_ram #(
		.WIDTH (L2_ROW_W),
		.DEPTH (L2_SETS),
		.AW    (L2_IDX_W)
	) u_l2_ram (
		.clk   (clk),
		.we    (l2_we),
		.waddr (l2_waddr),
		.wdata (l2_wdata),
		.raddr (l2_raddr),
		.rdata (l2_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
		end else if (state_q == ST_CLEAR && !clr_last) begin
			clr_idx_q <= clr_idx_q + CLR_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			l1_set_q <= l1_set;
			l2_set_q <= l2_set;
			l1_tag_q <= l1_tag;
			l2_tag_q <= l2_tag;
		end
	end

	// counters only move on a lookup, which needs an empty output register,
	// so they hold steady while a result waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l1_hit_q   <= '0;
			l1_miss_q  <= '0;
			l2_hit_q   <= '0;
			l2_miss_q  <= '0;
			mem_miss_q <= '0;
		end else if (look) begin
			if (l1_hit) begin
				if (l1_hit_q != '1) l1_hit_q <= l1_hit_q + CNT_BITS'(1);
			end else begin
				if (l1_miss_q != '1) l1_miss_q <= l1_miss_q + CNT_BITS'(1);
				if (l2_hit) begin
					if (l2_hit_q != '1) l2_hit_q <= l2_hit_q + CNT_BITS'(1);
				end else begin
					if (l2_miss_q != '1) l2_miss_q <= l2_miss_q + CNT_BITS'(1);
					if (mem_miss_q != '1) mem_miss_q <= mem_miss_q + CNT_BITS'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= look || (out_valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (look) begin
			hit_level_q <= l1_hit ? HIT_L1 : (l2_hit ? HIT_L2 : HIT_MEM);
		end
	end

	assign out_valid         = out_valid_q;
	assign hit_level         = hit_level_q;
	assign l1_hit_count      = l1_hit_q;
	assign l1_miss_count     = l1_miss_q;
	assign l2_hit_count      = l2_hit_q;
	assign l2_miss_count     = l2_miss_q;
	assign memory_miss_count = mem_miss_q;

endmodule

`default_nettype wire
